/* hw/rtl/p16exp_pkg.sv */
// ----------------------------------------------------------------------------
// p16exp_pkg
// shared constants and types for the posit16 (es=1) exponential pipeline
// ----------------------------------------------------------------------------
package p16exp_pkg;

    // log2(e) in q25
    localparam logic [25:0] LOG2E_Q     = 26'd48408813;

    // raw code ranges for the early-out cases
    localparam logic [15:0] POS_LIMIT   = 16'd28846;
    localparam logic [15:0] NEG_LIMIT   = 16'd36690;
    localparam logic [15:0] POS_ONE_LIM = 16'd192;
    localparam logic [15:0] NEG_ONE_LIM = 16'd65407;

    // fixed result codes
    localparam logic [15:0] P_ONE       = 16'h4000;
    localparam logic [15:0] P_MAXPOS    = 16'h7FFF;
    localparam logic [15:0] P_MINPOS    = 16'h0001;
    localparam logic [15:0] P_NAR       = 16'h8000;

    // operand base for the negative path
    localparam logic [25:0] NEG_BASE    = 26'h2000000;

    // largest regime length used when packing
    localparam logic [4:0]  RGM_MAX     = 5'd20;

    // horner coefficients of 2^t - 1
    localparam logic [12:0] C1          = 13'd7529;
    localparam logic [14:0] C2          = 15'd20487;
    localparam logic [22:0] C3          = 23'h4F8300;
    localparam logic [26:0] C4          = 27'h38CC980;
    localparam logic [33:0] C5          = 34'h1EBFFC800;
    localparam logic [34:0] C6          = 35'h2C5C83600;
    localparam logic [38:0] C_BIAS      = 39'd2048;

    typedef logic [24:0] t_tfrac;
    typedef logic [38:0] t_pfrac;

    // side information that travels with each request
    typedef struct packed {
        logic        spec;
        logic [15:0] spec_val;
        logic        neg;
        logic        ebit;
        logic [4:0]  rgm;
    } t_side;

endpackage

/* hw/rtl/p16exp_exp2_poly.sv */
// ----------------------------------------------------------------------------
// p16exp_exp2_poly
// six-stage horner pipeline: 25-bit fraction t in, 2^t - 1 with 37 fraction
// bits out, one multiply per stage, side information carried alongside
// ----------------------------------------------------------------------------
module p16exp_exp2_poly (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  p16exp_pkg::t_tfrac   i_t,
    input  p16exp_pkg::t_side    i_side,
    output logic                 o_vld,
    output p16exp_pkg::t_pfrac   o_frac,
    output p16exp_pkg::t_side    o_side
);

    logic [5:0]           r_vld;
    p16exp_pkg::t_tfrac   r_t    [5];
    p16exp_pkg::t_side    r_side [6];

    logic [11:0]          r_a1;
    logic [19:0]          r_a2;
    logic [23:0]          r_a3;
    logic [31:0]          r_a4;
    logic [32:0]          r_a5;
    logic [38:0]          r_a6;

    logic [14:0]          w_m2;
    logic [22:0]          w_m3;
    logic [26:0]          w_m4;
    logic [33:0]          w_m5;
    logic [34:0]          w_m6;

    logic [37:0]          w_p1;
    logic [39:0]          w_p2;
    logic [47:0]          w_p3;
    logic [51:0]          w_p4;
    logic [58:0]          w_p5;
    logic [59:0]          w_p6;

    logic [11:0]          n_a1;
    logic [19:0]          n_a2;
    logic [23:0]          n_a3;
    logic [31:0]          n_a4;
    logic [32:0]          n_a5;
    logic [38:0]          n_a6;

    assign w_p1 = 38'(i_t) * 38'(p16exp_pkg::C1);
    assign n_a1 = w_p1[37:26];

    assign w_m2 = p16exp_pkg::C2 + 15'(r_a1);
    assign w_p2 = 40'(r_t[0]) * 40'(w_m2);
    assign n_a2 = w_p2[39:20];

    assign w_m3 = p16exp_pkg::C3 + 23'(r_a2);
    assign w_p3 = 48'(r_t[1]) * 48'(w_m3);
    assign n_a3 = w_p3[47:24];

    assign w_m4 = p16exp_pkg::C4 + 27'(r_a3);
    assign w_p4 = 52'(r_t[2]) * 52'(w_m4);
    assign n_a4 = w_p4[51:20];

    assign w_m5 = p16exp_pkg::C5 + 34'(r_a4);
    assign w_p5 = 59'(r_t[3]) * 59'(w_m5);
    assign n_a5 = w_p5[58:26];

    assign w_m6 = p16exp_pkg::C6 + 35'(r_a5);
    assign w_p6 = 60'(r_t[4]) * 60'(w_m6);
    assign n_a6 = {1'b0, w_p6[59:22]} + p16exp_pkg::C_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_t[0]    <= i_t;
        r_t[1]    <= r_t[0];
        r_t[2]    <= r_t[1];
        r_t[3]    <= r_t[2];
        r_t[4]    <= r_t[3];
        r_side[0] <= i_side;
        r_side[1] <= r_side[0];
        r_side[2] <= r_side[1];
        r_side[3] <= r_side[2];
        r_side[4] <= r_side[3];
        r_side[5] <= r_side[4];
        r_a1      <= n_a1;
        r_a2      <= n_a2;
        r_a3      <= n_a3;
        r_a4      <= n_a4;
        r_a5      <= n_a5;
        r_a6      <= n_a6;
    end

    assign o_vld  = r_vld[5];
    assign o_frac = r_a6;
    assign o_side = r_side[5];

endmodule

/* hw/rtl/posit16_exp_fixed_point.sv */
// ----------------------------------------------------------------------------
// posit16_exp_fixed_point
// exp(x) for a 16-bit posit with es=1, fully pipelined fixed-point datapath
// ----------------------------------------------------------------------------
// channel  | dir | handshake       | payload
// request  | in  | start & !busy   | i_posit_in
// result   | out | o_strobe        | o_posit_out
//
// one request is taken every cycle; busy stays low.
// each result leaves in order, one per request, after passing the twelve
// register stages: decode, log2(e) multiply, split, six horner multiplies,
// packing, rounding shift, rounding add.
// reset clears the stage valid bits only; requests in flight are dropped.
// results cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module posit16_exp_fixed_point (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_posit_in,
    output logic        o_strobe,
    output logic [15:0] o_posit_out
);

    // decode
    logic [3:0]         w_run;
    logic               w_run_stop;
    logic [12:0]        w_sh_bits;
    logic               w_ebit;
    logic [11:0]        w_frac;
    logic [12:0]        w_mant;
    logic signed [6:0]  w_k2;
    logic signed [6:0]  w_ebit_s;
    logic signed [6:0]  w_e_pos;
    logic signed [6:0]  w_e_neg;
    logic [6:0]         w_e_abs;
    logic [6:0]         w_en_abs;
    logic [3:0]         w_s_neg;
    logic [25:0]        w_pos;
    logic [24:0]        w_wn0;
    logic [24:0]        w_wn;
    logic [25:0]        w_op_neg;

    logic               n_p1_vld;
    logic [25:0]        n_p1_op;
    p16exp_pkg::t_side  n_p1_side;

    logic               r_p1_vld;
    logic [25:0]        r_p1_op;
    p16exp_pkg::t_side  r_p1_side;

    // log2(e) multiply
    logic [51:0]        n_p2_prod;
    logic               r_p2_vld;
    logic [51:0]        r_p2_prod;
    p16exp_pkg::t_side  r_p2_side;

    // split into integer and fraction
    logic [31:0]        w_qp;
    logic [49:0]        w_nprod;
    logic [29:0]        w_qn;
    logic [5:0]         w_fl_half;
    p16exp_pkg::t_tfrac n_p3_t;
    p16exp_pkg::t_side  n_p3_side;
    logic               r_p3_vld;
    p16exp_pkg::t_tfrac r_p3_t;
    p16exp_pkg::t_side  r_p3_side;

    // polynomial
    logic               w_poly_vld;
    p16exp_pkg::t_pfrac w_poly_frac;
    p16exp_pkg::t_side  w_poly_side;

    // packing and rounding
    logic [59:0]        n_p10_v;
    logic               r_p10_vld;
    logic [59:0]        r_p10_v;
    p16exp_pkg::t_side  r_p10_side;

    logic [5:0]         w_shamt;
    logic [16:0]        n_p11_win;
    logic               n_p11_sticky;
    logic               r_p11_vld;
    logic [16:0]        r_p11_win;
    logic               r_p11_sticky;
    p16exp_pkg::t_side  r_p11_side;

    logic [15:0]        n_p12_out;
    logic               r_p12_vld;
    logic [15:0]        r_p12_out;

    assign busy = 1'b0;

    // regime run length from bit 13 downwards
    always_comb begin
        w_run      = '0;
        w_run_stop = 1'b0;
        for (int i = 13; i >= 0; i--) begin
            if (!w_run_stop && (i_posit_in[i] == i_posit_in[14])) begin
                w_run = w_run + 4'd1;
            end else begin
                w_run_stop = 1'b1;
            end
        end
    end

    always_comb begin
        w_sh_bits = 13'(i_posit_in[12:0] << w_run);
        w_ebit    = w_sh_bits[12];
        w_frac    = w_sh_bits[11:0];
        w_mant    = {1'b1, w_frac};
        w_k2      = signed'({2'b00, w_run, 1'b0});
        w_ebit_s  = signed'({6'd0, w_ebit});

        w_e_pos = (i_posit_in[14] ? (7'sd8 + w_k2) : (7'sd6 - w_k2)) + w_ebit_s;
        w_e_neg = (i_posit_in[14] ? (7'sd7 - w_k2) : (7'sd9 + w_k2)) - w_ebit_s;

        // positive operand: mantissa scaled by the exponent
        w_e_abs = 7'(-w_e_pos);
        if (w_e_pos < 0) begin
            w_pos = {13'd0, w_mant} >> w_e_abs[4:0];
        end else begin
            w_pos = {13'd0, w_mant} << w_e_pos[4:0];
        end

        // negative operand: two's complement mantissa, sign filled
        w_wn0    = {12'hFFF, 1'b0, w_frac};
        w_en_abs = 7'(-w_e_neg);
        w_s_neg  = (w_en_abs > 7'd13) ? 4'd13 : w_en_abs[3:0];
        if (w_e_neg < 0) begin
            w_wn = (w_wn0 >> w_s_neg) | (25'h1FFFFFF << (4'd13 - w_s_neg));
        end else begin
            w_wn = w_wn0 << w_e_neg[4:0];
        end
        w_op_neg = p16exp_pkg::NEG_BASE - {1'b0, w_wn};
    end

    // range classification
    always_comb begin
        n_p1_vld           = start && !busy;
        n_p1_side          = '0;
        n_p1_op            = w_pos;
        if (i_posit_in < p16exp_pkg::POS_ONE_LIM) begin
            n_p1_side.spec     = 1'b1;
            n_p1_side.spec_val = p16exp_pkg::P_ONE;
        end else if (i_posit_in < p16exp_pkg::POS_LIMIT) begin
            n_p1_side.neg      = 1'b0;
        end else if (i_posit_in > p16exp_pkg::NEG_ONE_LIM) begin
            n_p1_side.spec     = 1'b1;
            n_p1_side.spec_val = p16exp_pkg::P_ONE;
        end else if (i_posit_in > p16exp_pkg::NEG_LIMIT) begin
            n_p1_side.neg      = 1'b1;
            n_p1_op            = w_op_neg;
        end else if (i_posit_in < p16exp_pkg::P_NAR) begin
            n_p1_side.spec     = 1'b1;
            n_p1_side.spec_val = p16exp_pkg::P_MAXPOS;
        end else if (i_posit_in > p16exp_pkg::P_NAR) begin
            n_p1_side.spec     = 1'b1;
            n_p1_side.spec_val = p16exp_pkg::P_MINPOS;
        end else begin
            n_p1_side.spec     = 1'b1;
            n_p1_side.spec_val = p16exp_pkg::P_NAR;
        end
    end

    assign n_p2_prod = 52'(r_p1_op) * 52'(p16exp_pkg::LOG2E_Q);

    always_comb begin
        w_qp      = r_p2_prod[51:20];
        w_nprod   = 50'd0 - r_p2_prod[49:0];
        w_qn      = w_nprod[49:20];
        w_fl_half = w_qp[31:26];
        n_p3_side = r_p2_side;
        if (r_p2_side.neg) begin
            n_p3_t         = w_qn[24:0];
            n_p3_side.ebit = w_qn[25];
            n_p3_side.rgm  = {1'b0, ~w_qn[29:26]};
        end else begin
            n_p3_t         = w_qp[24:0];
            n_p3_side.ebit = w_qp[25];
            n_p3_side.rgm  = (w_fl_half > 6'(p16exp_pkg::RGM_MAX)) ?
                             p16exp_pkg::RGM_MAX : w_fl_half[4:0];
        end
    end

    p16exp_exp2_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p3_vld),
        .i_t     (r_p3_t),
        .i_side  (r_p3_side),
        .o_vld   (w_poly_vld),
        .o_frac  (w_poly_frac),
        .o_side  (w_poly_side)
    );

    // regime, exponent bit and fraction
    always_comb begin
        n_p10_v     = {21'd0, w_poly_frac};
        n_p10_v[37] = n_p10_v[37] | w_poly_side.ebit;
        if (w_poly_side.neg) begin
            n_p10_v[38] = 1'b1;
        end else begin
            for (int i = 0; i <= 20; i++) begin
                if (5'(i) <= w_poly_side.rgm) begin
                    n_p10_v[39 + i] = 1'b1;
                end
            end
        end
    end

    // guard, result window and sticky
    always_comb begin
        w_shamt      = 6'd24 + {1'b0, r_p10_side.rgm};
        n_p11_win    = 17'(r_p10_v >> w_shamt);
        n_p11_sticky = |(r_p10_v & ((60'd1 << w_shamt) - 60'd1));
    end

    // round to nearest even, or pass the early-out result through
    always_comb begin
        if (r_p11_side.spec) begin
            n_p12_out = r_p11_side.spec_val;
        end else begin
            n_p12_out = r_p11_win[16:1]
                      + {15'd0, r_p11_win[0] & (r_p11_sticky | r_p11_win[1])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p10_vld <= 1'b0;
            r_p11_vld <= 1'b0;
            r_p12_vld <= 1'b0;
        end else begin
            r_p1_vld  <= n_p1_vld;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p10_vld <= w_poly_vld;
            r_p11_vld <= r_p10_vld;
            r_p12_vld <= r_p11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_op      <= n_p1_op;
        r_p1_side    <= n_p1_side;
        r_p2_prod    <= n_p2_prod;
        r_p2_side    <= r_p1_side;
        r_p3_t       <= n_p3_t;
        r_p3_side    <= n_p3_side;
        r_p10_v      <= n_p10_v;
        r_p10_side   <= w_poly_side;
        r_p11_win    <= n_p11_win;
        r_p11_sticky <= n_p11_sticky;
        r_p11_side   <= r_p10_side;
        r_p12_out    <= n_p12_out;
    end

    assign o_strobe    = r_p12_vld;
    assign o_posit_out = r_p12_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##12 o_strobe)
        else $error("result missing twelve cycles after request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##12 !o_strobe)
        else $error("result without a request");

    a_nar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_posit_in == p16exp_pkg::P_NAR))
        |-> ##12 (o_posit_out == p16exp_pkg::P_NAR))
        else $error("nar not passed through");

    a_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_posit_in < p16exp_pkg::POS_ONE_LIM) ||
                            (i_posit_in > p16exp_pkg::NEG_ONE_LIM)))
        |-> ##12 (o_posit_out == p16exp_pkg::P_ONE))
        else $error("small argument did not give one");

endmodule

/* dv/posit16_exp_fixed_point_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// posit16_exp_fixed_point_tb
// self-checking bench for the posit16 (es=1) exponential pipeline
// ----------------------------------------------------------------------------
// requests through start/busy with a random gap between them, plus
// back-to-back runs
// bit-exact fixed-point predictor, oldest prediction checked per strobe
// directed codes on range boundaries, nar and saturation, then random codes
// weighted towards the computed ranges
// ----------------------------------------------------------------------------
module posit16_exp_fixed_point_tb;

    localparam logic [63:0] K_LOG2E    = p16exp_pkg::LOG2E_Q;
    localparam logic [63:0] K_NEG_BASE = p16exp_pkg::NEG_BASE;
    localparam logic [63:0] K_C1       = p16exp_pkg::C1;
    localparam logic [63:0] K_C2       = p16exp_pkg::C2;
    localparam logic [63:0] K_C3       = p16exp_pkg::C3;
    localparam logic [63:0] K_C4       = p16exp_pkg::C4;
    localparam logic [63:0] K_C5       = p16exp_pkg::C5;
    localparam logic [63:0] K_C6       = p16exp_pkg::C6;
    localparam logic [63:0] K_BIAS     = p16exp_pkg::C_BIAS;
    localparam int          RGM_CLIP   = p16exp_pkg::RGM_MAX;
    localparam int          DRAIN_CYC  = 20;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [15:0] i_posit_in  = 16'h0000;
    logic        busy;
    logic        o_strobe;
    logic [15:0] o_posit_out;

    logic [15:0] expected_posits[$];
    int          max_gap     = 5;
    int          n_requests  = 0;
    int          n_computed  = 0;
    int          n_checked   = 0;
    int          n_errors    = 0;

    posit16_exp_fixed_point i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_posit_in  (i_posit_in),
        .o_strobe    (o_strobe),
        .o_posit_out (o_posit_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // 2^t - 1 for a q25 fraction, 37 fraction bits plus bias
    function automatic logic [63:0] exp2_fraction(input logic [63:0] t);
        logic [63:0] a;
        a = (t * K_C1) >> 26;
        a = (t * (K_C2 + a)) >> 20;
        a = (t * (K_C3 + a)) >> 24;
        a = (t * (K_C4 + a)) >> 20;
        a = (t * (K_C5 + a)) >> 26;
        a = ((t * (K_C6 + a)) >> 22) + K_BIAS;
        return a;
    endfunction

    // round to nearest even at the bit set by the regime length
    function automatic logic [15:0] round_posit(input logic [63:0] v, input int m);
        logic [63:0] g;
        logic [63:0] r;
        if (m < 0) m = 0;
        if (m > 30) m = 30;
        g = 64'd1 << (24 + m);
        if ((v & g) != 0 && ((v & (g - 1)) != 0 || (v & (g << 1)) != 0))
            v = v + g;
        r = v >> (25 + m);
        return r[15:0];
    endfunction

    function automatic logic [15:0] posit_exp(input logic [15:0] code);
        logic [63:0] w;
        logic [63:0] frac;
        logic [63:0] ebit;
        int          e;
        int          fl;
        int          m;
        w = {48'd0, code};
        if (code < p16exp_pkg::POS_LIMIT) begin
            if (code < p16exp_pkg::POS_ONE_LIM)
                return p16exp_pkg::P_ONE;
            if (w[14]) begin
                e = 8;
                while (w[13]) begin
                    w = w << 1;
                    e = e + 2;
                end
            end else begin
                e = 6;
                while (!w[13]) begin
                    w = w << 1;
                    e = e - 2;
                end
            end
            if (w[12]) e = e + 1;
            w = (w & 64'hFFF) | 64'h1000;
            w = (e < 0) ? (w >> (-e)) : (w << e);
            w = (w * K_LOG2E) >> 20;
            fl = int'(w >> 25);
            frac = exp2_fraction(w & 64'h1FFFFFF);
            ebit = {26'd0, fl[0], 37'd0};
            m = fl >>> 1;
            if (m > RGM_CLIP) m = RGM_CLIP;
            w = ((64'h10000000000 << m) - 64'h8000000000) | ebit | frac;
            return round_posit(w, m);
        end
        if (code > p16exp_pkg::NEG_LIMIT) begin
            if (code > p16exp_pkg::NEG_ONE_LIM)
                return p16exp_pkg::P_ONE;
            if (w[14]) begin
                e = 7;
                while (w[13]) begin
                    w = w << 1;
                    e = e - 2;
                end
            end else begin
                e = 9;
                while (!w[13]) begin
                    w = w << 1;
                    e = e + 2;
                end
            end
            if (w[12]) e = e - 1;
            w = (w & 64'hFFF) | 64'h1FFE000;
            if (e < 0) begin
                if (e < -13) e = -13;
                w = (w >> (-e)) | (K_NEG_BASE - (64'd1 << (13 + e)));
            end else begin
                w = (w << e) & 64'h1FFFFFF;
            end
            w = (64'h4000000000000 - (K_NEG_BASE - w) * K_LOG2E) >> 20;
            w = w & 64'h3FFFFFFF;
            fl = int'(w >> 25) - 32;
            frac = exp2_fraction(w & 64'h1FFFFFF);
            ebit = {26'd0, fl[0], 37'd0};
            m = (-1 - fl) >>> 1;
            w = 64'h4000000000 | ebit | frac;
            return round_posit(w, m);
        end
        if (code < p16exp_pkg::P_NAR)
            return p16exp_pkg::P_MAXPOS;
        if (code > p16exp_pkg::P_NAR)
            return p16exp_pkg::P_MINPOS;
        return p16exp_pkg::P_NAR;
    endfunction

    task automatic send_request(input logic [15:0] code);
        int gap;
        gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_posit_in <= code;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        expected_posits.push_back(posit_exp(code));
        n_requests++;
        if ((code >= p16exp_pkg::POS_ONE_LIM && code < p16exp_pkg::POS_LIMIT) ||
            (code > p16exp_pkg::NEG_LIMIT && code <= p16exp_pkg::NEG_ONE_LIM))
            n_computed++;
    endtask

    always @(posedge i_clk) begin : result_check
        logic [15:0] want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_posits.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("[%0t] unexpected result 0x%04h", $time, o_posit_out);
            end else begin
                want = expected_posits.pop_front();
                n_checked++;
                if (o_posit_out !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("[%0t] mismatch: expected 0x%04h, got 0x%04h",
                                 $time, want, o_posit_out);
                end
            end
        end
    end

    task automatic test_boundaries();
        logic [15:0] codes[$];
        codes = '{16'h0000, 16'h0001, 16'h00BF, 16'h00C0, 16'h00C1, 16'h3FFF, 16'h4000,
                  16'h5555, 16'h70AD, 16'h70AE, 16'h7FFF, 16'h8000, 16'h8001, 16'h8F52,
                  16'h8F53, 16'hAAAA, 16'hC000, 16'hBFFF, 16'hFF7F, 16'hFF80, 16'hFFFF,
                  16'h1000, 16'h6000, 16'hE000, 16'hF0F0};
        foreach (codes[i])
            send_request(codes[i]);
    endtask

    task automatic test_random_codes(input int n);
        repeat (n)
            send_request(16'($urandom_range(0, 16'hFFFF)));
    endtask

    // only codes that go through the full datapath
    task automatic test_computed_ranges(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0)
                max_gap = ($urandom_range(0, 2) == 0) ? 0 : 5;
            if ($urandom_range(0, 1) == 0)
                send_request(16'($urandom_range(p16exp_pkg::POS_ONE_LIM,
                                                p16exp_pkg::POS_LIMIT - 1)));
            else
                send_request(16'($urandom_range(p16exp_pkg::NEG_LIMIT + 1,
                                                p16exp_pkg::NEG_ONE_LIM)));
        end
        max_gap = 5;
    endtask

    task automatic test_back_to_back(input int n);
        max_gap = 0;
        test_random_codes(n);
        max_gap = 5;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_boundaries();
        test_random_codes(300);
        test_computed_ranges(600);
        test_back_to_back(200);

        start <= 1'b0;
        while (expected_posits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("%0d requests sent (%0d through the computed ranges), %0d results checked",
                 n_requests, n_computed, n_checked);
        $display("%0d errors", n_errors);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #200000;
        $display("timeout with %0d results outstanding", expected_posits.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
